[src/lpht_pkg.sv]
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared codes and field widths of the linear-probe hash table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

	localparam int KEY_W    = 32;
	localparam int HASH_W   = 32;
	localparam int VALUE_W  = 32;
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 3;
	localparam int ECOUNT_W = 11;

	// slot word: {used, deleted, key, value}
	localparam int WORD_W   = 2 + KEY_W + VALUE_W;

	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam action_t ACT_ADD    = 2'd0;
	localparam action_t ACT_REMOVE = 2'd1;
	localparam action_t ACT_LOOKUP = 2'd2;

	localparam status_t ST_ADDED     = 3'd0;
	localparam status_t ST_PRESENT   = 3'd1;
	localparam status_t ST_FOUND     = 3'd2;
	localparam status_t ST_NOT_FOUND = 3'd3;
	localparam status_t ST_FULL      = 3'd4;

endpackage

`default_nettype wire

[src/lpht_mod.sv]
// ----------------------------------------------------------------------------
// lpht_mod
// Reduces a hash code modulo the slot count to give the first probe slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpht_mod #(
	parameter int SLOT_COUNT = 1024,
	parameter int IDX_W      = 10
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [lpht_pkg::HASH_W-1:0] dividend,
	output logic                           done,
	output logic [IDX_W-1:0]               rem
);
	import lpht_pkg::*;

	localparam bit IS_POW2 = (SLOT_COUNT & (SLOT_COUNT - 1)) == 0;

	generate
		if (IS_POW2) begin : g_mask
			logic             done_q;
			logic [IDX_W-1:0] rem_q;

			// take the low bits; done follows in the cycle after start
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					rem_q <= dividend[IDX_W-1:0];
				end
			end

			assign done = done_q;
			assign rem  = rem_q;
		end else begin : g_recip
			// floor(2^SHIFT / SLOT_COUNT) fits 32 bits since SLOT_COUNT > 2^(IDX_W-1);
			// the estimated quotient is low by at most one
			localparam int             SHIFT      = 31 + IDX_W;
			localparam logic [63:0]    RECIP_FULL = (64'd1 << SHIFT) / 64'(SLOT_COUNT);
			localparam logic [31:0]    RECIP      = RECIP_FULL[31:0];
			localparam logic [IDX_W:0] N_C        = (IDX_W + 1)'(SLOT_COUNT);

			logic [63:0]      prod;
			logic [63:0]      quot;
			logic             v_s1;
			logic [IDX_W:0]   q_s1;
			logic [IDX_W:0]   x_s1;
			logic [IDX_W:0]   diff;
			logic [IDX_W:0]   fix;
			logic             done_q;
			logic [IDX_W-1:0] rem_q;

			// estimate the quotient by reciprocal multiply
			always_comb begin
				prod = 64'(dividend) * 64'(RECIP);
				quot = prod >> SHIFT;
			end

			// remainder below 2N needs only the low bits; one correcting subtract
			always_comb begin
				diff = x_s1 - q_s1 * N_C;
				fix  = (diff >= N_C) ? (diff - N_C) : diff;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s1   <= 1'b0;
					done_q <= 1'b0;
				end else begin
					v_s1   <= start;
					done_q <= v_s1;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					q_s1 <= quot[IDX_W:0];
					x_s1 <= dividend[IDX_W:0];
				end
				if (v_s1) begin
					rem_q <= fix[IDX_W-1:0];
				end
			end

			assign done = done_q;
			assign rem  = rem_q;
		end
	endgenerate

endmodule

`default_nettype wire

[src/linear_probe_hash_table_core.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing hash table with linear probing and tombstones: add, remove
// and look up key-value pairs held in one slot memory.
// ----------------------------------------------------------------------------
//  channel   handshake        fields
//  request   start / busy     action, key, hash, value
//  result    done (strobe)    status, key_out, value_out, entry_count
//
//  From the accepting edge the hash is reduced modulo the slot count (mask
//  reduction when SLOT_COUNT is a power of two, registered reciprocal
//  reduction otherwise), then the slots are probed in order from the first;
//  the slot memory read port sets one probe per cycle. busy drops with the
//  strobe. After reset a clearing pass writes every slot with busy high.
//  The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table_core #(
	parameter int SLOT_COUNT = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire lpht_pkg::action_t             action,
	input  wire logic [lpht_pkg::KEY_W-1:0]    key,
	input  wire logic [lpht_pkg::HASH_W-1:0]   hash,
	input  wire logic [lpht_pkg::VALUE_W-1:0]  value,
	output logic                               done,
	output lpht_pkg::status_t                  status,
	output logic [lpht_pkg::KEY_W-1:0]         key_out,
	output logic [lpht_pkg::VALUE_W-1:0]       value_out,
	output logic [lpht_pkg::ECOUNT_W-1:0]      entry_count
);
	import lpht_pkg::*;

	localparam int IDX_W   = $clog2(SLOT_COUNT);
	localparam int COUNT_W = $clog2(SLOT_COUNT + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CLEAR = 2'd1;
	localparam logic [1:0] S_MOD   = 2'd2;
	localparam logic [1:0] S_PROBE = 2'd3;

	logic [1:0]         state_q;
	logic [IDX_W-1:0]   clr_q;
	logic [IDX_W-1:0]   slot_q;
	logic [IDX_W-1:0]   probe_q;
	logic [COUNT_W-1:0] live_q;
	action_t            action_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] value_q;

	logic               done_q;
	status_t            status_q;
	logic [KEY_W-1:0]   kout_q;
	logic [VALUE_W-1:0] vout_q;

	logic               accept;
	logic               mod_done;
	logic [IDX_W-1:0]   mod_rem;

	// slot memory
	logic [WORD_W-1:0]  mem [SLOT_COUNT];
	logic [WORD_W-1:0]  rd_q;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic               mem_we;
	logic [IDX_W-1:0]   wr_addr;
	logic [WORD_W-1:0]  wr_data;

	// probe decision
	logic               w_used;
	logic               w_del;
	logic [KEY_W-1:0]   w_key;
	logic [VALUE_W-1:0] w_val;
	logic               last_probe;
	logic [IDX_W-1:0]   next_slot;
	logic               finish;
	logic               advance;
	logic               cnt_inc;
	logic               cnt_dec;
	status_t            fin_status;
	logic [KEY_W-1:0]   fin_key;
	logic [VALUE_W-1:0] fin_val;
	logic [31:0]        live_ext;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	lpht_mod #(
		.SLOT_COUNT (SLOT_COUNT),
		.IDX_W      (IDX_W)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend (hash),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	assign w_used     = rd_q[WORD_W-1];
	assign w_del      = rd_q[WORD_W-2];
	assign w_key      = rd_q[KEY_W+VALUE_W-1:VALUE_W];
	assign w_val      = rd_q[VALUE_W-1:0];
	assign last_probe = (probe_q == LAST_IDX);
	assign next_slot  = (slot_q == LAST_IDX) ? '0 : slot_q + 1'b1;

	// decide on the slot word read for slot_q
	always_comb begin
		finish     = 1'b0;
		advance    = 1'b0;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		mem_we     = 1'b0;
		wr_addr    = slot_q;
		wr_data    = '0;
		fin_status = ST_NOT_FOUND;
		fin_key    = '0;
		fin_val    = '0;
		if (state_q == S_CLEAR) begin
			mem_we  = 1'b1;
			wr_addr = clr_q;
		end else if (state_q == S_PROBE) begin
			case (action_q) inside
				ACT_ADD: begin
					if (!w_used || w_del) begin
						finish     = 1'b1;
						mem_we     = 1'b1;
						wr_data    = {1'b1, 1'b0, key_q, value_q};
						cnt_inc    = 1'b1;
						fin_status = ST_ADDED;
					end else if (w_key == key_q) begin
						finish     = 1'b1;
						fin_status = ST_PRESENT;
					end else if (last_probe) begin
						finish     = 1'b1;
						fin_status = ST_FULL;
					end else begin
						advance = 1'b1;
					end
				end
				ACT_REMOVE, ACT_LOOKUP: begin
					if (!w_used) begin
						finish = 1'b1;
					end else if (!w_del && (w_key == key_q)) begin
						finish     = 1'b1;
						fin_status = ST_FOUND;
						fin_key    = w_key;
						fin_val    = w_val;
						if (action_q == ACT_REMOVE) begin
							mem_we  = 1'b1;
							wr_data = {1'b1, 1'b1, w_key, w_val};
							cnt_dec = (live_q != '0);
						end
					end else if (last_probe) begin
						finish = 1'b1;
					end else begin
						advance = 1'b1;
					end
				end
				default: begin
					finish = 1'b1;
				end
			endcase
		end
	end

	// read the first slot once reduced, then one slot per probe
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = next_slot;
		if (state_q == S_MOD && mod_done) begin
			rd_en   = 1'b1;
			rd_addr = mod_rem;
		end else if (advance) begin
			rd_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// sequencer and live count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			live_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= finish;
			if (cnt_inc) begin
				live_q <= live_q + 1'b1;
			end else if (cnt_dec) begin
				live_q <= live_q - 1'b1;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold request payload, probe position and result beat
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			key_q    <= key;
			value_q  <= value;
		end
		if (state_q == S_MOD && mod_done) begin
			slot_q  <= mod_rem;
			probe_q <= '0;
		end else if (advance) begin
			slot_q  <= next_slot;
			probe_q <= probe_q + 1'b1;
		end
		if (finish) begin
			status_q <= fin_status;
			kout_q   <= fin_key;
			vout_q   <= fin_val;
		end
	end

	assign live_ext    = 32'(live_q);
	assign done        = done_q;
	assign status      = status_q;
	assign key_out     = kout_q;
	assign value_out   = vout_q;
	assign entry_count = live_ext[ECOUNT_W-1:0];

	// checks
	a_done_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_PROBE))
		else $error("result beat without a finished probe");

	a_write_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_PROBE || state_q == S_CLEAR))
		else $error("slot write outside probe or clearing pass");

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= COUNT_W'(SLOT_COUNT))
		else $error("live count above slot count");

	a_add_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q == ST_ADDED) |-> (live_q == COUNT_W'($past(live_q) + 1'b1)))
		else $error("add did not raise the live count");

endmodule

`default_nettype wire
